// ===== hw/rtl/ccr_pkg.sv =====
// Package for the usage-count (generalized CLOCK) replacement block.
// Holds the request and response beat types shared by the top level.
// No dependencies.
package ccr_pkg;

  localparam int SLOT_BITS  = 10;
  localparam int TOTAL_BITS = 32;

  localparam logic ACT_HIT   = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [SLOT_BITS-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  victim_slot;
    logic                  was_free;
    logic [TOTAL_BITS-1:0] eviction_total;
  } rsp_t;

endpackage

// ===== hw/rtl/ccr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the usage counters of the replacement block. No dependencies.
module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/clock_usage_count_replacement_top.sv =====
// Top level of the usage-count (generalized CLOCK) replacement block.
// Depends on ccr_pkg (beat types) and ccr_ram (usage counter storage).
//
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_ready  ccr_pkg::req_t  (action, slot_index)
// rsp      out        rsp_valid/rsp_ready  ccr_pkg::rsp_t  (victim, was_free, total)
//
// A hit reads its counter, then writes it back one higher, saturating; an out-of-range hit is dropped.
// An allocate from the free range goes straight to the response; a sweep allocate
// reads one counter per slot visited and decrements it if nonzero, until one reads zero.
// After reset a clearing pass writes zero to every counter, with req_ready low.
// The response register frees the core: hits are taken while a response waits,
// and a finished allocate waits in its last state until the register is empty or being read.
module clock_usage_count_replacement_top #(
  parameter int SLOTS      = 1024,
  parameter int COUNT_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ccr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ccr_pkg::rsp_t rsp
);

  localparam int AW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    HIT_RD,
    HIT_WR,
    SW_RD,
    SW_CHK,
    DONE
  } state_t;

  state_t                            state;
  logic [AW-1:0]                     hand;
  logic [AW-1:0]                     hand_next;
  logic [AW-1:0]                     hit_addr;
  logic [HW-1:0]                     handed;
  logic [ccr_pkg::TOTAL_BITS-1:0]    evictions;
  logic [ccr_pkg::SLOT_BITS-1:0]     victim;
  logic                              fresh;
  logic                              hit_in_range;
  logic [31:0]                       handed_wide;
  logic [31:0]                       hand_wide;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  assign hand_next    = (hand == LAST_SLOT) ? '0 : hand + AW'(1);
  assign hit_in_range = 32'(req.slot_index) < SLOTS;
  assign handed_wide  = 32'(handed);
  assign hand_wide    = 32'(hand);
  assign req_ready    = (state == IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hand;
    ram_wdata = '0;
    ram_raddr = hand;
    case (state)
      CLEAR: begin
        ram_we = 1'b1;
      end
      HIT_RD: begin
        ram_raddr = hit_addr;
      end
      HIT_WR: begin
        ram_waddr = hit_addr;
        ram_we    = (ram_rdata != CNT_MAX);
        ram_wdata = ram_rdata + COUNT_BITS'(1);
      end
      SW_CHK: begin
        ram_we    = (ram_rdata != '0);
        ram_wdata = ram_rdata - COUNT_BITS'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ccr_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(SLOTS)
  ) u_counters (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      hand      <= '0;
      handed    <= '0;
      evictions <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          hand <= hand_next;
          if (hand == LAST_SLOT) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req_valid) begin
            if (req.action == ccr_pkg::ACT_HIT) begin
              hit_addr <= AW'(req.slot_index);
              if (hit_in_range) begin
                state <= HIT_RD;
              end
            end else if (handed_wide < SLOTS) begin
              victim <= handed_wide[ccr_pkg::SLOT_BITS-1:0];
              fresh  <= 1'b1;
              handed <= handed + HW'(1);
              state  <= DONE;
            end else begin
              evictions <= evictions + ccr_pkg::TOTAL_BITS'(1);
              fresh     <= 1'b0;
              state     <= SW_RD;
            end
          end
        end
        HIT_RD: begin
          state <= HIT_WR;
        end
        HIT_WR: begin
          state <= IDLE;
        end
        SW_RD: begin
          state <= SW_CHK;
        end
        SW_CHK: begin
          hand <= hand_next;
          if (ram_rdata == '0) begin
            victim <= hand_wide[ccr_pkg::SLOT_BITS-1:0];
            state  <= DONE;
          end else begin
            state <= SW_RD;
          end
        end
        DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.victim_slot    <= victim;
            rsp.was_free       <= fresh;
            rsp.eviction_total <= evictions;
            state              <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE || state == DONE) |-> !ram_we)
    else $error("Counter RAM written outside a working state.");

  a_handed_bound: assert property (@(posedge clk) disable iff (rst)
    handed_wide <= SLOTS)
    else $error("Handed-out count passed the number of slots.");

  a_evict_step: assert property (@(posedge clk) disable iff (rst)
    (evictions != $past(evictions)) |->
      (evictions == $past(evictions) + ccr_pkg::TOTAL_BITS'(1)))
    else $error("Eviction count moved by other than one.");

  a_sweep_only_full: assert property (@(posedge clk) disable iff (rst)
    (state == SW_CHK) |-> (handed_wide == SLOTS))
    else $error("Sweep ran before all slots were handed out.");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && (!rsp_valid || rsp_ready)) |=> (rsp_valid && state == IDLE))
    else $error("Finished allocate did not reach the response register.");

endmodule
